/* rtl/core/utf8d_pkg.sv */
// Package for the UTF-8 stream decoder: widths, register map and the
// record that passes from the byte front end to the result back end.
// No dependencies.
package utf8d_pkg;

    localparam int CP_W = 21;
    localparam int ASCII_W = 7;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register map, by word index
    localparam logic REG_REPLACEMENT = 1'b0;

    localparam logic [CP_W-1:0] REPLACEMENT_RESET = 21'd65533;

    // Results caused by one byte. The first result is a decoded code point
    // or an error; a second one, when present, is an ASCII byte or an error.
    typedef struct packed {
        logic               two;
        logic               err0;
        logic [CP_W-1:0]    cp0;
        logic               err1;
        logic [ASCII_W-1:0] cp1;
    } utf8d_entry_t;

endpackage

/* rtl/core/utf8d_byte_if.sv */
// Byte channel of the UTF-8 stream decoder: one raw byte per beat.
// No dependencies.
interface utf8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

/* rtl/core/utf8d_code_if.sv */
// Code point channel of the UTF-8 stream decoder: one result per beat.
// Depends on utf8d_pkg.
interface utf8d_code_if;
    logic                       valid;
    logic                       ready;
    logic [utf8d_pkg::CP_W-1:0] code_point;
    logic                       is_error;
    logic                       last_of_run;

    modport source (output valid, output code_point, output is_error,
                    output last_of_run, input ready);
    modport sink (input valid, input code_point, input is_error,
                  input last_of_run, output ready);
endinterface

/* rtl/core/utf8d_front.sv */
// Front end of the UTF-8 decoder: accepts bytes, tracks the open sequence
// and writes one record per byte that yields results. Depends on utf8d_pkg.
module utf8d_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             data_byte,
    input  logic                   end_of_input,
    input  logic                   q_full,
    output logic                   push,
    output utf8d_pkg::utf8d_entry_t push_entry
);
    import utf8d_pkg::*;

    typedef enum logic [1:0] {LEAD_ASCII, LEAD_OPEN, LEAD_BAD} lead_kind_t;

    typedef struct packed {
        lead_kind_t      kind;
        logic [CP_W-1:0] part;
        logic [1:0]      rem;
    } lead_t;

    function automatic lead_t classify(input logic [7:0] b);
        lead_t l;
        l.kind = LEAD_BAD;
        l.part = '0;
        l.rem  = 2'd0;
        unique case (b) inside
            8'b0???????: l.kind = LEAD_ASCII;
            8'b110?????:
            begin
                l.kind = LEAD_OPEN;
                l.part = CP_W'({b[4:0], 6'b0});
                l.rem  = 2'd1;
            end
            8'b1110????:
            begin
                l.kind = LEAD_OPEN;
                l.part = CP_W'({b[3:0], 12'b0});
                l.rem  = 2'd2;
            end
            8'b11110???:
            begin
                l.kind = LEAD_OPEN;
                l.part = {b[2:0], 18'b0};
                l.rem  = 2'd3;
            end
            default: l.kind = LEAD_BAD;
        endcase
        return l;
    endfunction

    logic [CP_W-1:0] part_reg, part_next;
    logic [1:0]      rem_reg, rem_next;
    logic [1:0]      count;
    logic            accept;
    lead_t           lead;
    logic [CP_W-1:0] cont_bits;
    utf8d_entry_t    entry;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign lead     = classify(data_byte);

    always_comb
    begin
        case (rem_reg)
            2'd3:    cont_bits = CP_W'({data_byte[5:0], 12'b0});
            2'd2:    cont_bits = CP_W'({data_byte[5:0], 6'b0});
            default: cont_bits = CP_W'(data_byte[5:0]);
        endcase
    end

    always_comb
    begin
        part_next  = part_reg;
        rem_next   = rem_reg;
        count      = 2'd0;
        entry.two  = 1'b0;
        entry.err0 = 1'b0;
        entry.cp0  = CP_W'(data_byte[ASCII_W-1:0]);
        entry.err1 = 1'b0;
        entry.cp1  = data_byte[ASCII_W-1:0];

        if (rem_reg == 2'd0)
        begin
            if (lead.kind == LEAD_OPEN)
            begin
                part_next = lead.part;
                rem_next  = lead.rem;
            end
            else
            begin
                entry.err0 = (lead.kind == LEAD_BAD);
                count      = 2'd1;
            end
        end
        else if (data_byte[7:6] == 2'b10)
        begin
            part_next = part_reg | cont_bits;
            rem_next  = rem_reg - 2'd1;
            if (rem_reg == 2'd1)
            begin
                entry.cp0 = part_next;
                count     = 2'd1;
                part_next = '0;
            end
        end
        else
        begin
            // Broken sequence: report it, then take this byte as a lead.
            entry.err0 = 1'b1;
            count      = 2'd1;
            part_next  = '0;
            rem_next   = 2'd0;
            if (lead.kind == LEAD_OPEN)
            begin
                part_next = lead.part;
                rem_next  = lead.rem;
            end
            else
            begin
                entry.err1 = (lead.kind == LEAD_BAD);
                count      = 2'd2;
            end
        end

        // Sequence cut off by the end of the buffer
        if (end_of_input && rem_next != 2'd0)
        begin
            if (count == 2'd0)
                entry.err0 = 1'b1;
            else
                entry.err1 = 1'b1;
            count     = count + 2'd1;
            part_next = '0;
            rem_next  = 2'd0;
        end
        entry.two = (count == 2'd2);
    end

    assign push       = accept && (count != 2'd0);
    assign push_entry = entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg <= '0;
            rem_reg  <= 2'd0;
        end
        else if (accept)
        begin
            part_reg <= part_next;
            rem_reg  <= rem_next;
        end
    end

    a_eoi_closes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_input |=> rem_reg == 2'd0)
        else $error("sequence left open after end of input");

    a_two_starts_err: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_entry.two |-> push_entry.err0)
        else $error("two results without a leading error");

    a_closed_part_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg == 2'd0 |-> part_reg == '0)
        else $error("partial code kept with no sequence open");
endmodule

/* rtl/core/utf8d_queue.sv */
// Short record queue between the decoder front and back ends.
// Depends on utf8d_pkg.
module utf8d_queue #(
    parameter int DEPTH = 2
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  utf8d_pkg::utf8d_entry_t push_entry,
    output logic                    full,
    input  logic                    pop,
    output logic                    head_valid,
    output utf8d_pkg::utf8d_entry_t head_entry
);
    import utf8d_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    utf8d_entry_t     mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("record written into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("record taken from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
endmodule

/* rtl/core/utf8d_back.sv */
// Back end of the UTF-8 decoder: expands queued records into result beats
// and holds the output register. Depends on utf8d_pkg.
module utf8d_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [utf8d_pkg::CP_W-1:0] replacement,
    input  logic                    head_valid,
    input  utf8d_pkg::utf8d_entry_t head_entry,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [utf8d_pkg::CP_W-1:0] code_point,
    output logic                    is_error,
    output logic                    last_of_run
);
    import utf8d_pkg::*;

    logic            valid_reg, valid_next;
    logic            phase_reg, phase_next;
    logic [CP_W-1:0] cp_reg, cp_next;
    logic            err_reg, err_next;
    logic            last_reg, last_next;
    logic            load;

    // The output register takes a new beat when empty or being drained.
    assign load = head_valid && (!valid_reg || out_ready);
    assign pop  = load && (phase_reg || !head_entry.two);

    always_comb
    begin
        phase_next = phase_reg;
        valid_next = valid_reg && !out_ready;
        cp_next    = cp_reg;
        err_next   = err_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            phase_next = !phase_reg && head_entry.two;
            if (phase_reg)
            begin
                err_next  = head_entry.err1;
                cp_next   = head_entry.err1 ? replacement : CP_W'(head_entry.cp1);
                last_next = 1'b1;
            end
            else
            begin
                err_next  = head_entry.err0;
                cp_next   = head_entry.err0 ? replacement : head_entry.cp0;
                last_next = !head_entry.two;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg   <= cp_next;
        err_reg  <= err_next;
        last_reg <= last_next;
    end

    assign out_valid   = valid_reg;
    assign code_point  = cp_reg;
    assign is_error    = err_reg;
    assign last_of_run = last_reg;

    a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> head_valid && head_entry.two)
        else $error("second result pending without a two-result record");

    a_phase_after_first: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> valid_reg && !last_reg)
        else $error("second result pending but first beat not held");

    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> valid_reg && last_reg)
        else $error("record retired without a final beat");
endmodule

/* rtl/core/utf8_stream_decoder.sv */
// UTF-8 stream decoder: byte channel in, code point channel out, with an
// APB-style register for the replacement code point.
// Depends on utf8d_pkg, utf8d_byte_if, utf8d_code_if and the utf8d_* modules.
//
// Usage
// A byte beat on byte_stream carries data_byte and end_of_input. Each byte
// gives zero, one or two code point beats on code_stream; the final beat
// that a byte causes has last_of_run set. Malformed or cut-off sequences give
// the replacement code point with is_error set. The replacement code point
// sits at byte address 0 of the register port and resets to 0xFFFD; the user
// must write it only while no beats are in flight; the block does not enforce
// this. A result record enters the queue at the edge that accepts its byte
// and then the output register that drives code_stream; a stall can hold it
// in the queue in between.
// Throughput: one byte per cycle while the queue is not full; a byte giving
// two results holds the single output stage for both of its beats.
// The front end decodes each accepted byte and, when it yields results,
// writes a record into a short queue; the back end turns records into beats,
// so a stall on code_stream fills the queue first and only then drops
// byte_stream.ready. Reset clears the open sequence, the queue and the output
// register; no clearing pass is needed before the first byte is accepted.
module utf8_stream_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    utf8d_byte_if.sink                      byte_stream,
    utf8d_code_if.source                    code_stream,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [utf8d_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [utf8d_pkg::APB_DATA_W-1:0] pwdata,
    output logic [utf8d_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import utf8d_pkg::*;

    logic [CP_W-1:0] replacement_reg;
    logic            cfg_write;
    logic            q_full;
    logic            push;
    logic            pop;
    logic            head_valid;
    utf8d_entry_t    push_entry;
    utf8d_entry_t    head_entry;

    // Register port: the word index is paddr[2]; only index zero exists.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == REG_REPLACEMENT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            replacement_reg <= REPLACEMENT_RESET;
        else if (cfg_write)
            replacement_reg <= pwdata[CP_W-1:0];
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_REPLACEMENT)
            prdata = APB_DATA_W'(replacement_reg);
    end

    utf8d_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (byte_stream.valid),
        .in_ready     (byte_stream.ready),
        .data_byte    (byte_stream.data_byte),
        .end_of_input (byte_stream.end_of_input),
        .q_full       (q_full),
        .push         (push),
        .push_entry   (push_entry)
    );

    utf8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    utf8d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .replacement (replacement_reg),
        .head_valid  (head_valid),
        .head_entry  (head_entry),
        .pop         (pop),
        .out_valid   (code_stream.valid),
        .out_ready   (code_stream.ready),
        .code_point  (code_stream.code_point),
        .is_error    (code_stream.is_error),
        .last_of_run (code_stream.last_of_run)
    );
endmodule
